// ===== hdl/sfe_pkg.sv =====
// constants and register codes for the sentence frame extractor
`timescale 1ns / 1ps
package sfe_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int PATTERN_MAX = 8;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int PLEN_W    = 4;
  localparam int TRAIL_W   = 2;
  localparam int FLEN_W    = 11;
  localparam int PHASE_W   = 2;
  localparam int PIDX_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILING_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LENGTH = 3'd4;

  localparam logic [PAT_W-1:0]   START_PATTERN_RST    = 64'd36;
  localparam logic [PLEN_W-1:0]  PATTERN_LENGTH_RST   = 4'd1;
  localparam logic [BYTE_W-1:0]  END_MARKER_RST       = 8'd42;
  localparam logic [TRAIL_W-1:0] TRAILING_COUNT_RST   = 2'd1;
  localparam logic [FLEN_W-1:0]  MAX_FRAME_LENGTH_RST = 11'd256;

  localparam logic [PHASE_W-1:0] PH_HUNT  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BODY  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TRAIL = 2'd2;

  localparam logic [FLEN_W-1:0] FRAME_CAP = FLEN_W'(MAX_FRAME);
  localparam logic [PLEN_W-1:0] PAT_CAP   = PLEN_W'(PATTERN_MAX);

endpackage

// ===== hdl/sentence_frame_extractor.sv =====
// top level of the sentence frame extractor
//
// usage:
//   input channel: data_byte with in_valid / in_stall, one raw byte per request
//   output channel: out_byte, frame_last, aborted with out_valid / out_stall
//   config channel: cfg_valid / cfg_ready, cfg_index, cfg_data; cfg_ready is
//   always high, write only while the block is idle
//   each byte is handled in the cycle it is taken; its result shows on the
//   output register in the next cycle; a byte that completes the start
//   pattern produces a burst of len requests (pattern_length clamped to 1..8),
//   one per cycle from the output register, and in_stall stays high until
//   the last of them is taken; other bytes give at most one result and a new
//   byte is taken every cycle, both only while the output keeps moving
//   when the receiver stalls, the output register holds and in_stall rises
//   as soon as a result waits that cannot move
//   reset (rst, synchronous) restores the register defaults, empties the
//   output register and returns to pattern hunting
`timescale 1ns / 1ps
module sentence_frame_extractor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfe_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfe_pkg::BYTE_W-1:0]    out_byte,
  output logic                          frame_last,
  output logic                          aborted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfe_pkg::PAT_W-1:0]     cfg_data
);
  import sfe_pkg::*;

  logic [PAT_W-1:0]   start_pattern;
  logic [PLEN_W-1:0]  pattern_length;
  logic [BYTE_W-1:0]  end_marker;
  logic [TRAIL_W-1:0] trailing_count;
  logic [FLEN_W-1:0]  max_frame_length;

  logic [PLEN_W-1:0]  match_position, match_position_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [FLEN_W-1:0]  frame_count, frame_count_next;
  logic [TRAIL_W-1:0] trailing_left, trailing_left_next;

  logic [PIDX_W-1:0]  burst_idx, burst_idx_next;
  logic [PIDX_W-1:0]  burst_left, burst_left_next;

  logic [BYTE_W-1:0]  res_byte;
  logic               res_last, res_abort, res_valid;

  logic [PLEN_W-1:0]  len, mp_base, mp_new;
  logic [FLEN_W-1:0]  limit;
  logic [TRAIL_W-1:0] tl_dec;
  logic               in_take, out_take, burst_more;

  assign cfg_ready  = 1'b1;
  assign out_take   = out_valid && !out_stall;
  assign burst_more = burst_left != '0;
  assign in_stall   = out_valid && !(out_take && !burst_more);
  assign in_take    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern    <= START_PATTERN_RST;
      pattern_length   <= PATTERN_LENGTH_RST;
      end_marker       <= END_MARKER_RST;
      trailing_count   <= TRAILING_COUNT_RST;
      max_frame_length <= MAX_FRAME_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_PATTERN:    start_pattern    <= cfg_data;
        REG_PATTERN_LENGTH:   pattern_length   <= cfg_data[PLEN_W-1:0];
        REG_END_MARKER:       end_marker       <= cfg_data[BYTE_W-1:0];
        REG_TRAILING_COUNT:   trailing_count   <= cfg_data[TRAIL_W-1:0];
        REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    priority if (pattern_length == '0) len = PLEN_W'(1);
    else if (pattern_length > PAT_CAP) len = PAT_CAP;
    else len = pattern_length;
    priority if (max_frame_length == '0) limit = FLEN_W'(1);
    else if (max_frame_length > FRAME_CAP) limit = FRAME_CAP;
    else limit = max_frame_length;
  end

  // per byte decision
  always_comb begin
    match_position_next = match_position;
    phase_next          = phase;
    frame_count_next    = frame_count;
    trailing_left_next  = trailing_left;
    res_valid           = 1'b0;
    res_byte            = data_byte;
    res_last            = 1'b0;
    res_abort           = 1'b0;
    burst_left_next     = '0;
    burst_idx_next      = PIDX_W'(1);
    tl_dec              = (trailing_left != '0) ? trailing_left - TRAIL_W'(1) : '0;
    mp_base             = (match_position >= len) ? '0 : match_position;
    if (data_byte == start_pattern[mp_base[PIDX_W-1:0]*BYTE_W +: BYTE_W]) begin
      mp_new = mp_base + PLEN_W'(1);
    end else if (data_byte == start_pattern[BYTE_W-1:0]) begin
      mp_new = PLEN_W'(1);
    end else begin
      mp_new = '0;
    end

    if (phase == PH_BODY || phase == PH_TRAIL) begin
      res_valid = 1'b1;
      if (frame_count >= limit) begin
        res_byte            = '0;
        res_abort           = 1'b1;
        phase_next          = PH_HUNT;
        match_position_next = '0;
        frame_count_next    = '0;
        trailing_left_next  = '0;
      end else begin
        frame_count_next = frame_count + FLEN_W'(1);
        if (phase == PH_BODY) begin
          if (data_byte == end_marker) begin
            if (trailing_count == '0) begin
              res_last            = 1'b1;
              phase_next          = PH_HUNT;
              match_position_next = '0;
              frame_count_next    = '0;
              trailing_left_next  = '0;
            end else begin
              trailing_left_next = trailing_count;
              phase_next         = PH_TRAIL;
            end
          end
        end else begin
          trailing_left_next = tl_dec;
          if (tl_dec == '0) begin
            res_last            = 1'b1;
            phase_next          = PH_HUNT;
            match_position_next = '0;
            frame_count_next    = '0;
          end
        end
      end
    end else begin
      phase_next          = PH_HUNT;
      match_position_next = mp_new;
      if (mp_new >= len) begin
        res_valid           = 1'b1;
        res_byte            = start_pattern[BYTE_W-1:0];
        burst_left_next     = PIDX_W'(len - PLEN_W'(1));
        match_position_next = '0;
        phase_next          = PH_BODY;
        frame_count_next    = FLEN_W'(len);
        trailing_left_next  = '0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= '0;
      phase          <= PH_HUNT;
      frame_count    <= '0;
      trailing_left  <= '0;
    end else if (in_take) begin
      match_position <= match_position_next;
      phase          <= phase_next;
      frame_count    <= frame_count_next;
      trailing_left  <= trailing_left_next;
    end
  end

  // output register and pattern burst
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      burst_left <= '0;
      burst_idx  <= '0;
    end else if (in_take) begin
      out_valid  <= res_valid;
      burst_left <= burst_left_next;
      burst_idx  <= burst_idx_next;
    end else if (out_take) begin
      if (burst_more) begin
        burst_left <= burst_left - PIDX_W'(1);
        burst_idx  <= burst_idx + PIDX_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_byte   <= res_byte;
      frame_last <= res_last;
      aborted    <= res_abort;
    end else if (out_take && burst_more) begin
      out_byte   <= start_pattern[burst_idx*BYTE_W +: BYTE_W];
      frame_last <= 1'b0;
      aborted    <= 1'b0;
    end
  end

endmodule

// ===== tb/sv/tb_sentence_frame_extractor.sv =====
// self-checking testbench for the sentence frame extractor
`timescale 1ns / 1ps
module tb_sentence_frame_extractor;
  import sfe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              is_last;
    logic              is_abort;
  } frame_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 frame_last;
  logic                 aborted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAT_W-1:0]     cfg_data = '0;

  // copy of the register file and frame state
  logic [PAT_W-1:0]   cur_pattern;
  logic [PLEN_W-1:0]  cur_plen;
  logic [BYTE_W-1:0]  cur_marker;
  logic [TRAIL_W-1:0] cur_trail;
  logic [FLEN_W-1:0]  cur_maxlen;
  logic [PLEN_W-1:0]  st_match;
  logic [PHASE_W-1:0] st_phase;
  logic [FLEN_W-1:0]  st_count;
  logic [TRAIL_W-1:0] st_trail_left;

  logic [BYTE_W-1:0] pending_bytes[$];
  frame_result_t     expected_frame_q[$];

  int  send_idle_max = 0;
  int  recv_idle_max = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  bit  byte_taken = 1'b0;
  int  bytes_sent = 0;
  int  results_checked = 0;
  int  frames_closed = 0;
  int  aborts_seen = 0;
  int  settings_used = 0;
  int  queued_bytes = 0;
  int  mismatches = 0;

  sentence_frame_extractor uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_last (frame_last),
    .aborted    (aborted),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("sentence_frame_extractor verification failed");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pattern_char(input int idx);
    return cur_pattern[(idx % 8) * 8 +: 8];
  endfunction

  function automatic int pattern_in_use();
    int n;
    n = int'(cur_plen);
    if (n < 1) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  task automatic expect_result(input logic [BYTE_W-1:0] b, input logic last, input logic ab);
    frame_result_t r;
    r.value    = b;
    r.is_last  = last;
    r.is_abort = ab;
    expected_frame_q.push_back(r);
  endtask

  task automatic restart_hunt();
    st_phase      = PH_HUNT;
    st_match      = '0;
    st_count      = '0;
    st_trail_left = '0;
  endtask

  task automatic advance_extractor(input logic [BYTE_W-1:0] b);
    int plen;
    int limit;
    plen  = pattern_in_use();
    limit = int'(cur_maxlen);
    if (limit < 1) limit = 1;
    if (limit > MAX_FRAME) limit = MAX_FRAME;
    if (st_phase == PH_BODY || st_phase == PH_TRAIL) begin
      if (st_count >= limit) begin
        expect_result('0, 1'b0, 1'b1);
        restart_hunt();
      end else begin
        st_count++;
        if (st_phase == PH_BODY) begin
          if (b == cur_marker && cur_trail == 0) begin
            expect_result(b, 1'b1, 1'b0);
            restart_hunt();
          end else begin
            if (b == cur_marker) begin
              st_trail_left = cur_trail;
              st_phase      = PH_TRAIL;
            end
            expect_result(b, 1'b0, 1'b0);
          end
        end else begin
          if (st_trail_left > 0) st_trail_left--;
          if (st_trail_left == 0) begin
            expect_result(b, 1'b1, 1'b0);
            restart_hunt();
          end else begin
            expect_result(b, 1'b0, 1'b0);
          end
        end
      end
    end else begin
      st_phase = PH_HUNT;
      if (st_match >= plen) st_match = '0;
      // a mismatching byte may still open a new match
      if (b == pattern_char(int'(st_match))) st_match++;
      else st_match = (b == pattern_char(0)) ? PLEN_W'(1) : '0;
      if (st_match >= plen) begin
        for (int i = 0; i < plen; i++) expect_result(pattern_char(i), 1'b0, 1'b0);
        st_match      = '0;
        st_phase      = PH_BODY;
        st_count      = FLEN_W'(plen);
        st_trail_left = '0;
      end
    end
  endtask

  // input side
  always @(posedge clk) begin : take_bytes
    if (!rst && in_valid && !in_stall) begin
      advance_extractor(data_byte);
      byte_taken = 1'b1;
      bytes_sent++;
    end
  end

  always @(negedge clk) begin : drive_bytes
    logic offer;
    offer = in_valid;
    if (byte_taken) begin
      offer      = 1'b0;
      byte_taken = 1'b0;
      send_gap   = $urandom_range(0, send_idle_max);
    end
    if (!rst && !offer) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_bytes.size() > 0) begin
        data_byte <= pending_bytes.pop_front();
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  // output side
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      recv_wait = $urandom_range(0, recv_idle_max);
      if (expected_frame_q.size() == 0) begin
        report_mismatch($sformatf("result byte %0h last %0b aborted %0b with none expected",
                                  out_byte, frame_last, aborted));
      end else begin
        want = expected_frame_q.pop_front();
        if (out_byte !== want.value)
          report_mismatch($sformatf("result %0d out_byte %0h, expected %0h",
                                    results_checked, out_byte, want.value));
        if (frame_last !== want.is_last)
          report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
                                    results_checked, frame_last, want.is_last));
        if (aborted !== want.is_abort)
          report_mismatch($sformatf("result %0d aborted %0b, expected %0b",
                                    results_checked, aborted, want.is_abort));
        if (want.is_last) frames_closed++;
        if (want.is_abort) aborts_seen++;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin : hold_counter
    if (hold_left > 0) hold_left--;
  end

  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0 || recv_wait > 0) begin
      if (recv_wait > 0) recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_PATTERN:    cur_pattern = val;
      REG_PATTERN_LENGTH:   cur_plen    = val[PLEN_W-1:0];
      REG_END_MARKER:       cur_marker  = val[BYTE_W-1:0];
      REG_TRAILING_COUNT:   cur_trail   = val[TRAIL_W-1:0];
      REG_MAX_FRAME_LENGTH: cur_maxlen  = val[FLEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [PAT_W-1:0] pat, input int plen, input int marker,
                              input int trail, input int maxlen);
    write_register(REG_START_PATTERN, pat);
    write_register(REG_PATTERN_LENGTH, PAT_W'(plen));
    write_register(REG_END_MARKER, PAT_W'(marker));
    write_register(REG_TRAILING_COUNT, PAT_W'(trail));
    write_register(REG_MAX_FRAME_LENGTH, PAT_W'(maxlen));
    settings_used++;
  endtask

  task automatic wait_drained(input int settle);
    while (pending_bytes.size() != 0 || in_valid || expected_frame_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // mostly whole sentences, some cut-off patterns and line noise
  task automatic queue_random_chunk(input int body_max);
    int pick;
    int n;
    int plen;
    logic [BYTE_W-1:0] c;
    pick = $urandom_range(0, 99);
    plen = pattern_in_use();
    if (pick < 70) begin
      for (int i = 0; i < plen; i++) pending_bytes.push_back(pattern_char(i));
      n = $urandom_range(0, body_max);
      for (int i = 0; i < n; i++) begin
        do c = BYTE_W'($urandom); while (c == cur_marker);
        pending_bytes.push_back(c);
      end
      pending_bytes.push_back(cur_marker);
      for (int i = 0; i < cur_trail; i++) pending_bytes.push_back(BYTE_W'($urandom));
      queued_bytes += plen + n + 1 + int'(cur_trail);
    end else if (pick < 85) begin
      n = $urandom_range(0, plen - 1);
      for (int i = 0; i < n; i++) pending_bytes.push_back(pattern_char(i));
      pending_bytes.push_back(BYTE_W'($urandom));
      queued_bytes += n + 1;
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) pending_bytes.push_back(BYTE_W'($urandom));
      queued_bytes += n;
    end
  endtask

  initial begin : stimulus
    int round;
    cur_pattern = START_PATTERN_RST;
    cur_plen    = PATTERN_LENGTH_RST;
    cur_marker  = END_MARKER_RST;
    cur_trail   = TRAILING_COUNT_RST;
    cur_maxlen  = MAX_FRAME_LENGTH_RST;
    restart_hunt();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_max = 15;
    recv_idle_max = 15;
    // reset setting: byte extremes, marker repeated as the trailing byte
    pending_bytes = '{8'h00, 8'hFF, 8'h24, 8'h41, 8'hFF, 8'h00, 8'h2A, 8'h2A};
    wait_drained(4);

    // three-char pattern, restart on a repeated first char, abort, marker closes at once
    load_setting(64'h0000_0000_0050_4724, 3, 8'h2A, 0, 4);
    pending_bytes = '{8'h24, 8'h24, 8'h47, 8'h50, 8'h78, 8'h79,
                      8'h24, 8'h47, 8'h50, 8'h2A};
    wait_drained(4);

    // limit of zero acts as one: pattern burst goes out, next byte aborts
    load_setting(64'h0000_0000_0050_4724, 2, 8'h2A, 0, 0);
    pending_bytes = '{8'h24, 8'h47, 8'h7A};
    wait_drained(4);

    round = 0;
    while (queued_bytes < 210) begin
      case (round % 4)
        0: begin
          load_setting({$urandom, $urandom}, 8, $urandom_range(0, 255), 3, 1024);
          send_idle_max = 15;
          recv_idle_max = 15;
        end
        1: begin
          load_setting({$urandom, $urandom}, 0, 8'h00, 0, 2047);
          send_idle_max = 0;
          recv_idle_max = 0;
        end
        2: begin
          load_setting({$urandom, $urandom}, 15, 8'hFF, 2, 12);
          send_idle_max = 0;
          recv_idle_max = 3;
        end
        default: begin
          load_setting({$urandom, $urandom}, $urandom_range(1, 8), $urandom_range(0, 255),
                       $urandom_range(0, 3), $urandom_range(1, 40));
          send_idle_max = $urandom_range(0, 15);
          recv_idle_max = $urandom_range(0, 15);
        end
      endcase
      if (round == 0) begin
        @(negedge clk);
        hold_left = 300;
      end
      for (int k = 0; k < 12 && queued_bytes < 210; k++) begin
        queue_random_chunk(12);
        // sender pause until the output has caught up
        if (k == 6) wait_drained(4);
      end
      wait_drained(4);
      round++;
    end

    wait_drained(20);
    $display("%0d bytes sent over %0d register settings, %0d results checked",
             bytes_sent, settings_used, results_checked);
    $display("%0d frames closed, %0d captures aborted, %0d mismatches",
             frames_closed, aborts_seen, mismatches);
    if (mismatches == 0) begin
      $display("sentence_frame_extractor verification clean");
    end else begin
      $display("sentence_frame_extractor verification failed");
    end
    $finish;
  end

endmodule
